@@ rtl/lbp_pkg.sv @@
// lbp_pkg: shared constants, input action codes and the queued command word
// for the LSB-first bit packer. No dependencies.
`default_nettype none

package lbp_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned BITCNT_W  = 7;
  localparam int unsigned BYTECNT_W = 4;
  localparam int unsigned FILL_W    = 4;
  localparam int unsigned MAX_BITS  = 64;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned MAX_BYTES = MAX_BITS / BYTE_BITS;

  typedef enum logic [1:0] {
    ACT_BITS     = 2'd0,
    ACT_BYTES    = 2'd1,
    ACT_COMPLETE = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // complete is queued as an align with zero bytes
  typedef struct packed {
    logic                is_bytes;
    logic [DATA_W-1:0]   data;
    logic [BITCNT_W-1:0] count;
  } cmd_t;

  function automatic logic [BYTE_BITS-1:0] low_mask(input logic [FILL_W-1:0] n);
    logic [BYTE_BITS-1:0] m;
    if (n >= FILL_W'(BYTE_BITS)) begin
      m = '1;
    end else begin
      m = BYTE_BITS'((9'd1 << n) - 9'd1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lbp_if.sv @@
// lbp_item_if / lbp_byte_if: valid/ready channels for input words and
// output stream bytes. Depends on lbp_pkg.
`default_nettype none

interface lbp_item_if import lbp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [DATA_W-1:0]    data_bits;
  logic [BITCNT_W-1:0]  bit_count;
  logic [BYTECNT_W-1:0] byte_count;

  modport source (output valid, action, data_bits, bit_count, byte_count, input ready);
  modport sink   (input valid, action, data_bits, bit_count, byte_count, output ready);
endinterface

interface lbp_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

@@ rtl/lsb_first_bit_packer_core.sv @@
// lsb_first_bit_packer_core: top level, front classifier, command queue and
// back packer. Depends on lbp_pkg, lbp_if, lbp_front, lbp_queue, lbp_back.
//
//   port    dir   handshake     payload
//   item    sink  valid/ready   action, data_bits, bit_count, byte_count
//   result  src   valid/ready   out_byte, last
//
// One output byte per cycle once a command is running, while the output
// does not stall; each word is loaded in the back part's idle state, and
// byte and complete words also pass through the align state.
// Sync reset clears the queue, the pending byte, the fill level and output.
// Input stalls only when the queue (QUEUE_DEPTH words) is full; output
// stalls hold the back part but not the front.
`default_nettype none

module lsb_first_bit_packer_core import lbp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  lbp_item_if.sink   item,
  lbp_byte_if.source result
);

  cmd_t wr_cmd;
  cmd_t rd_cmd;
  logic push;
  logic full;
  logic pop;
  logic empty;

  lbp_front u_front (
    .item (item),
    .cmd  (wr_cmd),
    .push (push),
    .full (full)
  );

  lbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (full),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .empty  (empty)
  );

  lbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (rd_cmd),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

@@ rtl/lbp_front.sv @@
// lbp_front: accepts input words, saturates counts and turns each word into
// a queued command; bit words with zero count and unused codes are dropped. Uses lbp_pkg.
`default_nettype none

module lbp_front import lbp_pkg::*; (
  lbp_item_if.sink item,
  output cmd_t     cmd,
  output logic     push,
  input  logic     full
);

  action_t             act;
  logic                keep;
  logic [BITCNT_W-1:0] nbits;
  logic [BITCNT_W-1:0] nbytes;

  assign act = action_t'(item.action);

  always_comb begin
    nbits  = (item.bit_count > BITCNT_W'(MAX_BITS)) ? BITCNT_W'(MAX_BITS) : item.bit_count;
    nbytes = (item.byte_count > BYTECNT_W'(MAX_BYTES)) ? BITCNT_W'(MAX_BYTES)
                                                       : BITCNT_W'(item.byte_count);
    cmd.data     = item.data_bits;
    cmd.is_bytes = 1'b1;
    cmd.count    = '0;
    keep         = 1'b0;
    case (act)
      ACT_BITS: begin
        cmd.is_bytes = 1'b0;
        cmd.count    = nbits;
        keep         = (nbits != '0);
      end
      ACT_BYTES: begin
        cmd.count = nbytes;
        keep      = 1'b1;
      end
      ACT_COMPLETE: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item.ready = !full;
  assign push       = item.valid && !full && keep;

endmodule

`default_nettype wire

@@ rtl/lbp_queue.sv @@
// lbp_queue: short command queue between front and back, register array
// with head read. Uses lbp_pkg for cmd_t.
`default_nettype none

module lbp_queue import lbp_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lbp_back.sv @@
// lbp_back: executes queued commands, holds the pending byte and fill level,
// drives the output byte register. Uses lbp_pkg and lbp_byte_if.
`default_nettype none

module lbp_back import lbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  lbp_byte_if.source result
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BITS  = 4'b0010,
    S_ALIGN = 4'b0100,
    S_BYTES = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [DATA_W-1:0]    data, data_next;
  logic [BITCNT_W-1:0]  rem, rem_next;
  logic [BYTE_BITS-1:0] pend, pend_next;
  logic [FILL_W-1:0]    fill, fill_next;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 out_last;

  logic                 slot_free;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic                 emit_last;
  logic [FILL_W-1:0]    room;
  logic [FILL_W-1:0]    take;
  logic [BITCNT_W-1:0]  rem_take;
  logic [BYTE_BITS-1:0] chunk;

  assign slot_free = !out_valid || result.ready;

  always_comb begin
    room     = fill[3] ? FILL_W'(BYTE_BITS) : FILL_W'(BYTE_BITS) - fill;
    take     = (rem <= BITCNT_W'(room)) ? rem[FILL_W-1:0] : room;
    rem_take = rem - BITCNT_W'(take);
    chunk    = data[BYTE_BITS-1:0] & low_mask(take);
  end

  always_comb begin
    state_next = state;
    data_next  = data;
    rem_next   = rem;
    pend_next  = pend;
    fill_next  = fill;
    emit       = 1'b0;
    emit_byte  = pend;
    emit_last  = 1'b0;
    pop        = 1'b0;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          data_next  = head.data;
          rem_next   = head.count;
          state_next = head.is_bytes ? S_ALIGN : S_BITS;
        end
      end
      S_BITS: begin
        // a full pending byte leaves when the next bit arrives or on an align
        if (fill[3]) begin
          if (slot_free) begin
            emit       = 1'b1;
            emit_last  = (rem <= BITCNT_W'(BYTE_BITS));
            pend_next  = chunk;
            fill_next  = take;
            data_next  = data >> take;
            rem_next   = rem_take;
            state_next = (rem_take == '0) ? S_IDLE : S_BITS;
          end
        end else begin
          pend_next  = pend | BYTE_BITS'(chunk << fill[2:0]);
          fill_next  = fill + take;
          data_next  = data >> take;
          rem_next   = rem_take;
          state_next = (rem_take == '0) ? S_IDLE : S_BITS;
        end
      end
      S_ALIGN: begin
        if (slot_free) begin
          if (fill != '0) begin
            emit      = 1'b1;
            emit_last = (rem == '0);
          end
          pend_next  = '0;
          fill_next  = '0;
          state_next = (rem == '0) ? S_IDLE : S_BYTES;
        end
      end
      S_BYTES: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_byte  = data[7:0];
          emit_last  = (rem == BITCNT_W'(1));
          data_next  = data >> BYTE_BITS;
          rem_next   = rem - 1'b1;
          state_next = (rem == BITCNT_W'(1)) ? S_IDLE : S_BYTES;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      fill  <= fill_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    rem  <= rem_next;
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.last     = out_last;

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(BYTE_BITS))
    else $error("fill level above one byte");

  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    !fill[3] |-> ((pend >> fill[2:0]) == '0))
    else $error("pending byte has bits above fill level");

  a_bits_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_BITS) |-> (rem != '0))
    else $error("bit command running with nothing left");

  a_bytes_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_BYTES) |-> (rem != '0))
    else $error("byte command running with nothing left");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("byte emitted over an unread output");

endmodule

`default_nettype wire

@@ sim/tb_lsb_first_bit_packer_core.sv @@
// Testbench for lsb_first_bit_packer_core: sends directed and random words and
// checks every output byte against a behavioural packer model kept in this file.
// Depends on lbp_pkg, lbp_if and the packer RTL.
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer_core;
  import lbp_pkg::*;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } stream_byte_t;

  logic clk;
  logic rst;

  lbp_item_if item_ch ();
  lbp_byte_if byte_ch ();

  lsb_first_bit_packer_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (byte_ch)
  );

  // packer model state and pending expectations
  logic [7:0]   pend_byte;
  logic [3:0]   pend_fill;
  stream_byte_t stream_q[$];

  int err_count;
  bit tx_idle_on;
  bit rx_stall_on;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("error at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // model of the packer: updates state and queues the bytes this word emits
  function automatic void pack_word(input action_t act, input logic [63:0] d,
                                    input logic [6:0] bc, input logic [3:0] yc);
    logic [7:0] outs[$];
    int nbits;
    int nbytes;
    stream_byte_t sb;
    case (act)
      ACT_BITS: begin
        nbits = (bc > MAX_BITS) ? MAX_BITS : int'(bc);
        for (int k = 0; k < nbits; k++) begin
          if (pend_fill >= BYTE_BITS) begin
            outs.push_back(pend_byte);
            pend_byte = '0;
            pend_fill = '0;
          end
          if (d[k]) pend_byte[pend_fill[2:0]] = 1'b1;
          pend_fill = pend_fill + 4'd1;
        end
      end
      ACT_BYTES, ACT_COMPLETE: begin
        if (pend_fill != 0) begin
          outs.push_back(pend_byte);
          pend_byte = '0;
          pend_fill = '0;
        end
        if (act == ACT_BYTES) begin
          nbytes = (yc > MAX_BYTES) ? MAX_BYTES : int'(yc);
          for (int k = 0; k < nbytes; k++) outs.push_back(d[8*k +: 8]);
        end
      end
      default: ;
    endcase
    foreach (outs[i]) begin
      sb.val  = outs[i];
      sb.last = (i == outs.size() - 1);
      stream_q.push_back(sb);
    end
  endfunction

  // valid is only dropped when a gap follows, so it never toggles within one step
  task automatic send_word(input action_t act, input logic [63:0] d,
                           input logic [6:0] bc, input logic [3:0] yc);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.action     <= act;
    item_ch.data_bits  <= d;
    item_ch.bit_count  <= bc;
    item_ch.byte_count <= yc;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pack_word(act, d, bc, yc);
  endtask

  // sink side ready
  initial begin
    int stall;
    stall = 0;
    byte_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        byte_ch.ready <= 1'b0;
        stall--;
      end else begin
        byte_ch.ready <= 1'b1;
        if (rx_stall_on && $urandom_range(0, 99) < 25) begin
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        end
      end
    end
  end

  // output checker
  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (stream_q.size() == 0) begin
        report_mismatch("unexpected byte", 64'(byte_ch.out_byte), 64'd0);
      end else begin
        want = stream_q.pop_front();
        if (byte_ch.out_byte !== want.val)
          report_mismatch("out_byte", 64'(byte_ch.out_byte), 64'(want.val));
        if (byte_ch.last !== want.last)
          report_mismatch("last", 64'(byte_ch.last), 64'(want.last));
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_bits_directed();
    send_word(ACT_BITS, '1, 7'd0, 4'd0);
    send_word(ACT_BITS, 64'h1, 7'd1, 4'd0);
    send_word(ACT_BITS, 64'h7f, 7'd7, 4'd15);
    send_word(ACT_BITS, 64'h0, 7'd1, 4'd0);          // releases the held full byte
    send_word(ACT_BITS, '1, 7'd64, 4'd0);
    send_word(ACT_BITS, 64'ha5a5_5a5a_c3c3_3c3c, 7'd127, 4'd0);  // saturates
    send_word(ACT_BITS, rand64(), 7'd65, 4'd0);
    send_word(ACT_BITS, 64'hffff_ffff_ffff_fffa, 7'd3, 4'd0);     // upper bits ignored
  endtask

  task automatic test_bytes_directed();
    send_word(ACT_BYTES, '1, 7'd127, 4'd0);          // align only
    send_word(ACT_BYTES, 64'h0, 7'd0, 4'd0);         // nothing pending
    send_word(ACT_BYTES, 64'h0123_4567_89ab_cdef, 7'd0, 4'd8);
    send_word(ACT_BYTES, '1, 7'd0, 4'd15);
    send_word(ACT_BYTES, 64'h0, 7'd0, 4'd9);
    send_word(ACT_BITS, 64'h15, 7'd5, 4'd0);
    send_word(ACT_BYTES, 64'hdead_beef_0011_2233, 7'd64, 4'd3);
  endtask

  task automatic test_complete_directed();
    send_word(ACT_COMPLETE, 64'h0, 7'd0, 4'd0);      // nothing pending
    send_word(ACT_BITS, 64'h3c, 7'd8, 4'd0);
    send_word(ACT_COMPLETE, '1, 7'd127, 4'd15);
    send_word(ACT_BITS, 64'h1abc, 7'd13, 4'd0);
    send_word(ACT_NONE, '1, 7'd5, 4'd8);             // unused code
    send_word(ACT_COMPLETE, rand64(), 7'd64, 4'd8);
    send_word(ACT_NONE, '1, 7'd127, 4'd15);
  endtask

  task automatic run_random(input int n_words);
    int done;
    int r;
    action_t act;
    logic [6:0] bc;
    logic [3:0] yc;
    done = 0;
    while (done < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 50) act = ACT_BITS;
      else if (r < 70) act = ACT_BYTES;
      else if (r < 90) act = ACT_COMPLETE;
      else act = ACT_NONE;
      bc = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 64)) : 7'($urandom_range(65, 127));
      yc = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      send_word(act, rand64(), bc, yc);
      done++;
    end
  endtask

  task automatic test_random_with_idle();
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    run_random(360);
  endtask

  task automatic test_random_streaming();
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    run_random(120);
  endtask

  initial begin
    int waited;
    err_count   = 0;
    pend_byte   = '0;
    pend_fill   = '0;
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    rst = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.action     = ACT_BITS;
    item_ch.data_bits  = '0;
    item_ch.bit_count  = '0;
    item_ch.byte_count = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_bits_directed();
    test_bytes_directed();
    test_complete_directed();
    test_random_with_idle();
    test_random_streaming();

    item_ch.valid <= 1'b0;
    rx_stall_on = 1'b0;
    waited = 0;
    while (stream_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (stream_q.size() != 0)
      report_mismatch("bytes never emitted", 64'(stream_q.size()), 64'd0);
    repeat (40) @(posedge clk);

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
